>>> design/rcs_pkg.sv
// Relay channel supervisor: shared types, command and status codes,
// register map and register reset values. No dependencies.
package rcs_pkg;

  localparam int CFG_W   = 26;
  localparam int CNT_W   = 16;
  localparam int TOT_W   = 32;
  localparam int APB_AW  = 5;
  localparam int APB_DW  = 32;
  localparam int TMO_REGS = 4;

  typedef logic [2:0]       cmd_t;
  typedef logic [1:0]       chan_t;
  typedef logic [1:0]       status_t;
  typedef logic [CFG_W-1:0] cfg_word_t;

  localparam cmd_t CMD_TICK    = 3'd0;
  localparam cmd_t CMD_START   = 3'd1;
  localparam cmd_t CMD_STOP    = 3'd2;
  localparam cmd_t CMD_ESTOP   = 3'd3;
  localparam cmd_t CMD_RELEASE = 3'd4;

  localparam status_t ST_OK        = 2'd0;
  localparam status_t ST_ESTOP     = 2'd1;
  localparam status_t ST_INTERLOCK = 2'd2;
  localparam status_t ST_COOLDOWN  = 2'd3;

  // register indexes (byte address = 4 * index)
  localparam logic [2:0] REG_PUMP_A_TMO = 3'd0;
  localparam logic [2:0] REG_PUMP_B_TMO = 3'd1;
  localparam logic [2:0] REG_FAN_TMO    = 3'd2;
  localparam logic [2:0] REG_LIGHT_TMO  = 3'd3;
  localparam logic [2:0] REG_COOLDOWN   = 3'd4;
  localparam logic [2:0] REG_MIN_ON     = 3'd5;
  localparam logic [2:0] REG_ALLOW_BOTH = 3'd6;

  localparam cfg_word_t RST_PUMP_A_TMO = 26'd300000;
  localparam cfg_word_t RST_PUMP_B_TMO = 26'd300000;
  localparam cfg_word_t RST_FAN_TMO    = 26'd3600000;
  localparam cfg_word_t RST_LIGHT_TMO  = 26'd43200000;
  localparam cfg_word_t RST_COOLDOWN   = 26'd30000;
  localparam cfg_word_t RST_MIN_ON     = 26'd5000;

  typedef struct packed {
    logic [TMO_REGS-1:0][CFG_W-1:0] timeout;
    cfg_word_t                      cooldown;
    cfg_word_t                      min_on;
    logic                           allow_both;
  } cfg_t;

endpackage

>>> design/rcs_ifs.sv
// Relay channel supervisor: valid/ready channel interfaces for command
// beats and result beats. Depends on rcs_pkg.
interface rcs_in_if import rcs_pkg::*; ();
  logic  valid;
  logic  ready;
  cmd_t  cmd;
  chan_t channel;

  modport source (output valid, cmd, channel, input ready);
  modport sink   (input valid, cmd, channel, output ready);
endinterface

interface rcs_out_if import rcs_pkg::*; ();
  logic             valid;
  logic             ready;
  status_t          status;
  logic [3:0]       relay_mask;
  logic             estop_active;
  logic [3:0]       timed_out_mask;
  logic             short_run;
  logic [CNT_W-1:0] pump_a_starts;
  logic [CNT_W-1:0] pump_b_starts;
  logic [TOT_W-1:0] pump_a_total_ms;
  logic [TOT_W-1:0] pump_b_total_ms;

  modport source (output valid, status, relay_mask, estop_active, timed_out_mask,
                  short_run, pump_a_starts, pump_b_starts, pump_a_total_ms,
                  pump_b_total_ms, input ready);
  modport sink   (input valid, status, relay_mask, estop_active, timed_out_mask,
                  short_run, pump_a_starts, pump_b_starts, pump_a_total_ms,
                  pump_b_total_ms, output ready);
endinterface

>>> design/rcs_cfg_regs.sv
// Relay channel supervisor: APB-style configuration register file.
// Depends on rcs_pkg.
module rcs_cfg_regs import rcs_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  cfg_t       cfg_r;
  logic       wr_en;
  logic [2:0] idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = paddr[APB_AW-1:2];
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.timeout[0] <= RST_PUMP_A_TMO;
      cfg_r.timeout[1] <= RST_PUMP_B_TMO;
      cfg_r.timeout[2] <= RST_FAN_TMO;
      cfg_r.timeout[3] <= RST_LIGHT_TMO;
      cfg_r.cooldown   <= RST_COOLDOWN;
      cfg_r.min_on     <= RST_MIN_ON;
      cfg_r.allow_both <= 1'b0;
    end else if (wr_en) begin
      case (idx)
        REG_PUMP_A_TMO: cfg_r.timeout[0] <= pwdata[CFG_W-1:0];
        REG_PUMP_B_TMO: cfg_r.timeout[1] <= pwdata[CFG_W-1:0];
        REG_FAN_TMO:    cfg_r.timeout[2] <= pwdata[CFG_W-1:0];
        REG_LIGHT_TMO:  cfg_r.timeout[3] <= pwdata[CFG_W-1:0];
        REG_COOLDOWN:   cfg_r.cooldown   <= pwdata[CFG_W-1:0];
        REG_MIN_ON:     cfg_r.min_on     <= pwdata[CFG_W-1:0];
        REG_ALLOW_BOTH: cfg_r.allow_both <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_PUMP_A_TMO: prdata = APB_DW'(cfg_r.timeout[0]);
      REG_PUMP_B_TMO: prdata = APB_DW'(cfg_r.timeout[1]);
      REG_FAN_TMO:    prdata = APB_DW'(cfg_r.timeout[2]);
      REG_LIGHT_TMO:  prdata = APB_DW'(cfg_r.timeout[3]);
      REG_COOLDOWN:   prdata = APB_DW'(cfg_r.cooldown);
      REG_MIN_ON:     prdata = APB_DW'(cfg_r.min_on);
      REG_ALLOW_BOTH: prdata = APB_DW'(cfg_r.allow_both);
      default:        prdata = '0;
    endcase
  end

endmodule

>>> design/relay_channel_supervisor_top.sv
// Relay channel supervisor top level: command register, state update and
// result register. Depends on rcs_pkg, rcs_ifs and rcs_cfg_regs.
//
// Usage:
//   in_bus carries one command beat (cmd, channel): tick of 1 ms, start,
//   stop, emergency stop or release. out_bus returns exactly one result beat
//   per command: status, relay mask, estop latch, timeout mask, short-run
//   flag, pump start counters and pump run totals.
//   A command beat is captured into an input register, evaluated against the
//   channel state by one pass of logic and lands in the result register.
//   One beat per cycle is sustained while out_bus.ready stays high; the
//   channel state is updated at the edge that loads the result register.
//   When the receiver stalls, the result register holds and the input
//   register still takes one more beat; in_bus.ready drops only when both are
//   full. Synchronous active-low reset turns every relay off, clears the
//   estop latch, counters and totals, empties both registers and loads the
//   configuration defaults. Configuration is written over the APB-style port
//   (register i at byte address 4*i); the user must do so only while no
//   command is in flight, which the block itself does not enforce.
module relay_channel_supervisor_top import rcs_pkg::*; #(
  parameter int CHANNELS  = 4,
  parameter int TIME_BITS = 26
) (
  input  logic              clk,
  input  logic              rst_n,
  rcs_in_if.sink            in_bus,
  rcs_out_if.source         out_bus,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  localparam logic [31:0] TMAX = 32'((64'd1 << TIME_BITS) - 64'd1);

  typedef logic [TIME_BITS-1:0] tval_t;

  cfg_t cfg;

  rcs_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // pipeline control
  logic    s1_valid_r;
  cmd_t    s1_cmd_r;
  chan_t   s1_chan_r;
  logic    out_valid_r;
  logic    advance;

  // channel state
  logic             chan_on_r   [CHANNELS];
  logic             relay_nxt   [CHANNELS];
  tval_t            run_r       [CHANNELS];
  tval_t            run_nxt     [CHANNELS];
  logic             latch_r,    latch_nxt;
  tval_t            est_r,      est_nxt;
  logic [CNT_W-1:0] starts_r    [2];
  logic [CNT_W-1:0] starts_nxt  [2];
  logic [TOT_W-1:0] total_r     [2];
  logic [TOT_W-1:0] total_nxt   [2];

  // result registers
  status_t    status_r,  status_nxt;
  logic [3:0] tmask_r,   tmask_nxt;
  logic       short_r,   short_nxt;

  logic [31:0] limit   [CHANNELS];
  logic        off_req [CHANNELS];
  tval_t       off_val [CHANNELS];
  logic        ch_ok;
  logic        other_on;
  logic [31:0] tmo_ext;
  logic [3:0]  relay_mask;

  function automatic tval_t sat_inc(input tval_t v);
    return (&v) ? v : v + 1'b1;
  endfunction

  assign advance      = !out_valid_r || out_bus.ready;
  assign in_bus.ready = !s1_valid_r || advance;

  // effective timeout per channel, clamped to the counter range
  always_comb begin
    tmo_ext = '0;
    for (int c = 0; c < CHANNELS; c++) begin
      if (c < TMO_REGS) begin
        tmo_ext  = 32'(cfg.timeout[2'(c)]);
        limit[c] = (tmo_ext > TMAX) ? TMAX : tmo_ext;
      end else begin
        limit[c] = TMAX;
      end
    end
  end

  always_comb begin
    relay_nxt  = chan_on_r;
    run_nxt    = run_r;
    latch_nxt  = latch_r;
    est_nxt    = est_r;
    starts_nxt = starts_r;
    total_nxt  = total_r;
    status_nxt = ST_OK;
    tmask_nxt  = '0;
    short_nxt  = 1'b0;
    ch_ok      = (int'(s1_chan_r) < CHANNELS);
    other_on   = s1_chan_r[0] ? chan_on_r[0] : chan_on_r[1];
    for (int c = 0; c < CHANNELS; c++) begin
      off_req[c] = 1'b0;
      off_val[c] = run_r[c];
    end

    case (s1_cmd_r)
      CMD_TICK: begin
        for (int c = 0; c < CHANNELS; c++) begin
          if (chan_on_r[c]) begin
            run_nxt[c] = sat_inc(run_r[c]);
            if (32'(run_nxt[c]) >= limit[c]) begin
              off_req[c] = 1'b1;
              off_val[c] = run_nxt[c];
              if (c < 4) tmask_nxt[2'(c)] = 1'b1;
            end
          end
        end
        if (latch_r) est_nxt = sat_inc(est_r);
      end
      CMD_START: begin
        if (ch_ok) begin
          if (latch_r) begin
            status_nxt = ST_ESTOP;
          end else if (!s1_chan_r[1] && !cfg.allow_both && other_on) begin
            status_nxt = ST_INTERLOCK;
          end else begin
            for (int c = 0; c < CHANNELS; c++) begin
              if (int'(s1_chan_r) == c && !chan_on_r[c]) begin
                relay_nxt[c] = 1'b1;
                run_nxt[c]   = '0;
                if (c < 2) starts_nxt[1'(c)] = starts_r[1'(c)] + 1'b1;
              end
            end
          end
        end
      end
      CMD_STOP: begin
        for (int c = 0; c < CHANNELS; c++)
          if (int'(s1_chan_r) == c && chan_on_r[c]) off_req[c] = 1'b1;
      end
      CMD_ESTOP: begin
        latch_nxt = 1'b1;
        est_nxt   = '0;
        for (int c = 0; c < CHANNELS; c++)
          if (chan_on_r[c]) off_req[c] = 1'b1;
      end
      CMD_RELEASE: begin
        if (latch_r) begin
          if (32'(est_r) < 32'(cfg.cooldown)) begin
            status_nxt = ST_COOLDOWN;
          end else begin
            latch_nxt = 1'b0;
            est_nxt   = '0;
          end
        end
      end
      default: ;
    endcase

    // switch-off: pumps fold their run time into the totals
    for (int c = 0; c < CHANNELS; c++) begin
      if (off_req[c]) begin
        relay_nxt[c] = 1'b0;
        run_nxt[c]   = '0;
        if (c < 2) begin
          if (32'(off_val[c]) < 32'(cfg.min_on)) short_nxt = 1'b1;
          total_nxt[1'(c)] = total_r[1'(c)] + 32'(off_val[c]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      latch_r     <= 1'b0;
      est_r       <= '0;
      for (int c = 0; c < CHANNELS; c++) begin
        chan_on_r[c] <= 1'b0;
        run_r[c]     <= '0;
      end
      for (int p = 0; p < 2; p++) begin
        starts_r[p] <= '0;
        total_r[p]  <= '0;
      end
    end else begin
      if (in_bus.ready) s1_valid_r <= in_bus.valid;
      if (advance) out_valid_r <= s1_valid_r;
      if (advance && s1_valid_r) begin
        chan_on_r  <= relay_nxt;
        run_r      <= run_nxt;
        latch_r    <= latch_nxt;
        est_r      <= est_nxt;
        starts_r   <= starts_nxt;
        total_r    <= total_nxt;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_bus.valid && in_bus.ready) begin
      s1_cmd_r  <= in_bus.cmd;
      s1_chan_r <= in_bus.channel;
    end
    if (advance && s1_valid_r) begin
      status_r <= status_nxt;
      tmask_r  <= tmask_nxt;
      short_r  <= short_nxt;
    end
  end

  for (genvar g = 0; g < 4; g++) begin : g_mask
    if (g < CHANNELS) begin : g_on
      assign relay_mask[g] = chan_on_r[g];
    end else begin : g_off
      assign relay_mask[g] = 1'b0;
    end
  end

  // state only moves together with a new result, so it can drive the beat
  assign out_bus.valid           = out_valid_r;
  assign out_bus.status          = status_r;
  assign out_bus.relay_mask      = relay_mask;
  assign out_bus.estop_active    = latch_r;
  assign out_bus.timed_out_mask  = tmask_r;
  assign out_bus.short_run       = short_r;
  assign out_bus.pump_a_starts   = starts_r[0];
  assign out_bus.pump_b_starts   = starts_r[1];
  assign out_bus.pump_a_total_ms = total_r[0];
  assign out_bus.pump_b_total_ms = total_r[1];

endmodule

>>> verif/relay_channel_supervisor_top_tb.sv
// Testbench for relay_channel_supervisor_top: directed command table, then random
// command phases under several register settings, checked beat by beat against a
// local predictor. Depends on rcs_pkg, rcs_ifs and the RTL under design/.
module relay_channel_supervisor_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rcs_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int PHASES = 6;
  localparam int PHASE_ITEMS = 115;
  localparam int STALL_CYCLES = 120;
  localparam cmd_t CMD_RSVD_LO = 3'd5;
  localparam cmd_t CMD_RSVD_MID = 3'd6;
  localparam cmd_t CMD_RSVD_HI = 3'd7;
  localparam cfg_word_t RUN_MS_MAX = '1;

  typedef struct packed {
    status_t          status;
    logic [3:0]       relay_mask;
    logic             estop_active;
    logic [3:0]       timed_out_mask;
    logic             short_run;
    logic [CNT_W-1:0] pump_a_starts;
    logic [CNT_W-1:0] pump_b_starts;
    logic [TOT_W-1:0] pump_a_total_ms;
    logic [TOT_W-1:0] pump_b_total_ms;
  } relay_result_t;

  typedef enum logic {ROW_CMD, ROW_CFG} row_kind_e;

  typedef struct packed {
    row_kind_e     kind;
    cmd_t          cmd;
    chan_t         ch;
    logic [2:0]    reg_idx;
    cfg_word_t     value;
    logic          typed;
    relay_result_t want;
  } script_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic psel;
  logic penable;
  logic pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic pready;

  rcs_in_if  in_bus ();
  rcs_out_if out_bus ();

  relay_channel_supervisor_top dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // predictor state
  cfg_t             pred_cfg;
  logic [3:0]       chan_on;
  cfg_word_t        run_ms [4];
  logic             estop_latch;
  cfg_word_t        estop_ms;
  logic [CNT_W-1:0] pump_starts [2];
  logic [TOT_W-1:0] pump_total [2];

  relay_result_t pending_results [$];
  int unsigned   mismatches = 0;
  bit            no_idle = 1'b0;
  bit            stall_go = 1'b0;
  bit            rx_stall = 1'b0;
  int unsigned   rx_beats = 0;
  int unsigned   rx_seen = 0;
  int            rx_gap = 0;

  function automatic bit chan_off(int c);
    bit was_short;
    was_short = 1'b0;
    if (!chan_on[c]) return 1'b0;
    if (c < 2) begin
      was_short = run_ms[c] < pred_cfg.min_on;
      pump_total[c] = pump_total[c] + run_ms[c];
    end
    chan_on[c] = 1'b0;
    run_ms[c] = '0;
    return was_short;
  endfunction

  function automatic relay_result_t step_supervisor(cmd_t cmd, chan_t ch);
    relay_result_t r;
    r = '0;
    case (cmd)
      CMD_TICK: begin
        for (int c = 0; c < 4; c++) begin
          if (chan_on[c]) begin
            if (run_ms[c] != RUN_MS_MAX) run_ms[c]++;
            if (run_ms[c] >= pred_cfg.timeout[c]) begin
              if (chan_off(c)) r.short_run = 1'b1;
              r.timed_out_mask[c] = 1'b1;
            end
          end
        end
        if (estop_latch && estop_ms != RUN_MS_MAX) estop_ms++;
      end
      CMD_START: begin
        if (estop_latch) begin
          r.status = ST_ESTOP;
        end else if (ch < 2 && !pred_cfg.allow_both && chan_on[ch ^ 2'd1]) begin
          r.status = ST_INTERLOCK;
        end else if (!chan_on[ch]) begin
          chan_on[ch] = 1'b1;
          run_ms[ch] = '0;
          if (ch < 2) pump_starts[ch[0]]++;
        end
      end
      CMD_STOP: r.short_run = chan_off(int'(ch));
      CMD_ESTOP: begin
        estop_latch = 1'b1;
        estop_ms = '0;
        for (int c = 0; c < 4; c++)
          if (chan_off(c)) r.short_run = 1'b1;
      end
      CMD_RELEASE: begin
        if (estop_latch) begin
          if (estop_ms < pred_cfg.cooldown) begin
            r.status = ST_COOLDOWN;
          end else begin
            estop_latch = 1'b0;
            estop_ms = '0;
          end
        end
      end
      default: ;
    endcase
    r.relay_mask = chan_on;
    r.estop_active = estop_latch;
    r.pump_a_starts = pump_starts[0];
    r.pump_b_starts = pump_starts[1];
    r.pump_a_total_ms = pump_total[0];
    r.pump_b_total_ms = pump_total[1];
    return r;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  function automatic relay_result_t beat(status_t st, logic [3:0] mask, logic estop,
                                         logic shrt, logic [CNT_W-1:0] a_starts,
                                         logic [CNT_W-1:0] b_starts,
                                         logic [TOT_W-1:0] a_total);
    relay_result_t r;
    r = '0;
    r.status = st;
    r.relay_mask = mask;
    r.estop_active = estop;
    r.short_run = shrt;
    r.pump_a_starts = a_starts;
    r.pump_b_starts = b_starts;
    r.pump_a_total_ms = a_total;
    return r;
  endfunction

  function automatic script_row_t cmd_row(cmd_t cmd, chan_t ch);
    script_row_t r;
    r = '0;
    r.kind = ROW_CMD;
    r.cmd = cmd;
    r.ch = ch;
    return r;
  endfunction

  function automatic script_row_t checked_row(cmd_t cmd, chan_t ch, relay_result_t want);
    script_row_t r;
    r = cmd_row(cmd, ch);
    r.typed = 1'b1;
    r.want = want;
    return r;
  endfunction

  function automatic script_row_t cfg_row(logic [2:0] idx, cfg_word_t value);
    script_row_t r;
    r = '0;
    r.kind = ROW_CFG;
    r.reg_idx = idx;
    r.value = value;
    return r;
  endfunction

  function automatic cfg_word_t small_or_max(int unsigned hi);
    return ($urandom_range(0, 7) == 0) ? RUN_MS_MAX : cfg_word_t'($urandom_range(0, hi));
  endfunction

  task automatic write_reg(logic [2:0] idx, cfg_word_t value);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= APB_DW'(value);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_COOLDOWN:   pred_cfg.cooldown = value;
      REG_MIN_ON:     pred_cfg.min_on = value;
      REG_ALLOW_BOTH: pred_cfg.allow_both = value[0];
      default:        pred_cfg.timeout[idx[1:0]] = value;
    endcase
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic send_cmd(cmd_t cmd, chan_t ch, logic typed, relay_result_t want);
    int gap;
    relay_result_t predicted;
    gap = no_idle ? 0 : $urandom_range(0, 16);
    @(negedge clk);
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_bus.valid <= 1'b1;
    in_bus.cmd <= cmd;
    in_bus.channel <= ch;
    do @(posedge clk); while (!in_bus.ready);
    predicted = step_supervisor(cmd, ch);
    pending_results.push_back(typed ? want : predicted);
  endtask

  // sender goes quiet until every outstanding result beat has been checked
  task automatic drain_results();
    @(negedge clk);
    in_bus.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // long receiver stall, counted here while the sender keeps offering beats
  initial begin : rx_stall_proc
    wait (stall_go);
    @(posedge clk);
    rx_stall = 1'b1;
    repeat (STALL_CYCLES) @(posedge clk);
    rx_stall = 1'b0;
  end

  // receiver: a fresh random gap after every accepted result beat, none when no_idle is set
  always @(negedge clk) begin
    if (rx_seen != rx_beats) begin
      rx_seen = rx_beats;
      rx_gap = no_idle ? 0 : $urandom_range(0, 16);
    end
    if (!rst_n || rx_stall) begin
      out_bus.ready <= 1'b0;
    end else if (rx_gap > 0) begin
      rx_gap = rx_gap - 1;
      out_bus.ready <= 1'b0;
    end else begin
      out_bus.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin : result_check
    relay_result_t want;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      rx_beats++;
      if (pending_results.size() == 0) begin
        $error("result beat with no command outstanding");
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        check_field("status", 32'(want.status), 32'(out_bus.status));
        check_field("relay_mask", 32'(want.relay_mask), 32'(out_bus.relay_mask));
        check_field("estop_active", 32'(want.estop_active), 32'(out_bus.estop_active));
        check_field("timed_out_mask", 32'(want.timed_out_mask),
                    32'(out_bus.timed_out_mask));
        check_field("short_run", 32'(want.short_run), 32'(out_bus.short_run));
        check_field("pump_a_starts", 32'(want.pump_a_starts), 32'(out_bus.pump_a_starts));
        check_field("pump_b_starts", 32'(want.pump_b_starts), 32'(out_bus.pump_b_starts));
        check_field("pump_a_total_ms", want.pump_a_total_ms, out_bus.pump_a_total_ms);
        check_field("pump_b_total_ms", want.pump_b_total_ms, out_bus.pump_b_total_ms);
      end
    end
  end

  initial begin : watchdog
    int unsigned cycle_cnt;
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("relay_channel_supervisor_top_tb failed");
    $finish;
  end

  initial begin : stimulus
    script_row_t script [30];
    cfg_t        phase_cfg;
    int          pick;
    cmd_t        rcmd;

    rst_n = 1'b0;
    in_bus.valid = 1'b0;
    in_bus.cmd = CMD_TICK;
    in_bus.channel = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;

    pred_cfg.timeout[0] = RST_PUMP_A_TMO;
    pred_cfg.timeout[1] = RST_PUMP_B_TMO;
    pred_cfg.timeout[2] = RST_FAN_TMO;
    pred_cfg.timeout[3] = RST_LIGHT_TMO;
    pred_cfg.cooldown = RST_COOLDOWN;
    pred_cfg.min_on = RST_MIN_ON;
    pred_cfg.allow_both = 1'b0;
    chan_on = '0;
    foreach (run_ms[c]) run_ms[c] = '0;
    estop_latch = 1'b0;
    estop_ms = '0;
    foreach (pump_starts[p]) begin
      pump_starts[p] = '0;
      pump_total[p] = '0;
    end

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset defaults first: interlock, repeated start/stop, estop lockout,
    // reserved opcodes; then zero cooldown/timeout and both-pumps mode
    script = '{
      checked_row(CMD_TICK,    2'd0, beat(ST_OK,        4'h0, 1'b0, 1'b0, 0, 0, 0)),
      checked_row(CMD_START,   2'd0, beat(ST_OK,        4'h1, 1'b0, 1'b0, 1, 0, 0)),
      checked_row(CMD_START,   2'd1, beat(ST_INTERLOCK, 4'h1, 1'b0, 1'b0, 1, 0, 0)),
      checked_row(CMD_START,   2'd0, beat(ST_OK,        4'h1, 1'b0, 1'b0, 1, 0, 0)),
      cmd_row(CMD_TICK, 2'd3),
      checked_row(CMD_STOP,    2'd0, beat(ST_OK,        4'h0, 1'b0, 1'b1, 1, 0, 1)),
      checked_row(CMD_STOP,    2'd0, beat(ST_OK,        4'h0, 1'b0, 1'b0, 1, 0, 1)),
      cmd_row(CMD_START, 2'd2),
      cmd_row(CMD_START, 2'd3),
      cmd_row(CMD_START, 2'd1),
      checked_row(CMD_ESTOP,   2'd2, beat(ST_OK,        4'h0, 1'b1, 1'b1, 1, 1, 1)),
      checked_row(CMD_START,   2'd3, beat(ST_ESTOP,     4'h0, 1'b1, 1'b0, 1, 1, 1)),
      checked_row(CMD_RELEASE, 2'd1, beat(ST_COOLDOWN,  4'h0, 1'b1, 1'b0, 1, 1, 1)),
      cmd_row(CMD_RSVD_LO, 2'd3),
      cmd_row(CMD_RSVD_MID, 2'd2),
      cmd_row(CMD_RSVD_HI, 2'd1),
      cfg_row(REG_COOLDOWN, '0),
      cmd_row(CMD_RELEASE, 2'd0),
      cfg_row(REG_PUMP_A_TMO, '0),
      cmd_row(CMD_START, 2'd0),
      cmd_row(CMD_TICK, 2'd0),
      cfg_row(REG_ALLOW_BOTH, cfg_word_t'(1)),
      cfg_row(REG_PUMP_A_TMO, RUN_MS_MAX),
      cfg_row(REG_MIN_ON, '0),
      cmd_row(CMD_START, 2'd0),
      cmd_row(CMD_START, 2'd1),
      cmd_row(CMD_STOP, 2'd1),
      cmd_row(CMD_ESTOP, 2'd0),
      cmd_row(CMD_ESTOP, 2'd3),
      cmd_row(CMD_RELEASE, 2'd2)
    };

    foreach (script[i]) begin
      if (script[i].kind == ROW_CFG) begin
        drain_results();
        write_reg(script[i].reg_idx, script[i].value);
      end else begin
        send_cmd(script[i].cmd, script[i].ch, script[i].typed, script[i].want);
      end
    end

    for (int p = 0; p < PHASES; p++) begin
      drain_results();
      case (p)
        2: begin
          // every tick trips all running channels, every pump stop is short
          phase_cfg.timeout = '0;
          phase_cfg.cooldown = '0;
          phase_cfg.min_on = RUN_MS_MAX;
          phase_cfg.allow_both = 1'b0;
        end
        3: begin
          for (int t = 0; t < TMO_REGS; t++) phase_cfg.timeout[t] = RUN_MS_MAX;
          phase_cfg.cooldown = RUN_MS_MAX;
          phase_cfg.min_on = '0;
          phase_cfg.allow_both = 1'b1;
        end
        default: begin
          for (int t = 0; t < TMO_REGS; t++) phase_cfg.timeout[t] = small_or_max(40);
          phase_cfg.cooldown = cfg_word_t'($urandom_range(0, 25));
          phase_cfg.min_on = cfg_word_t'($urandom_range(0, 30));
          phase_cfg.allow_both = 1'($urandom_range(0, 1));
        end
      endcase
      for (int t = 0; t < TMO_REGS; t++)
        write_reg(REG_PUMP_A_TMO + 3'(t), phase_cfg.timeout[t]);
      write_reg(REG_COOLDOWN, phase_cfg.cooldown);
      write_reg(REG_MIN_ON, phase_cfg.min_on);
      write_reg(REG_ALLOW_BOTH, cfg_word_t'(phase_cfg.allow_both));
      no_idle = (p == 4);

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 45)      rcmd = CMD_TICK;
        else if (pick < 67) rcmd = CMD_START;
        else if (pick < 79) rcmd = CMD_STOP;
        else if (pick < 83) rcmd = CMD_ESTOP;
        else if (pick < 94) rcmd = CMD_RELEASE;
        else                rcmd = CMD_RSVD_LO + cmd_t'($urandom_range(0, 2));
        send_cmd(rcmd, chan_t'($urandom_range(0, 3)), 1'b0, '0);
        // long receiver stall while commands keep coming: both stages fill
        if (p == 1 && n == 20) stall_go = 1'b1;
      end
    end

    drain_results();
    if (mismatches == 0) begin
      $display("relay_channel_supervisor_top_tb passed");
    end else begin
      $display("relay_channel_supervisor_top_tb failed");
    end
    $finish;
  end

endmodule
